FILE: rtl/core/trc_pkg.sv
// shared types, character codes and helpers for the text readability counter
package trc_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3f;

    // one classified text byte as it travels from front to back
    typedef struct packed {
        logic       alnum;
        logic       vowel;
        logic       ender;
        logic       final_byte;
        logic [7:0] chr;
    } t_item;

    function automatic logic vowel_letter(input logic [7:0] c);
        return (c == CH_A) || (c == CH_E) || (c == CH_I) || (c == CH_O) ||
               (c == CH_U) || (c == CH_Y);
    endfunction

endpackage

FILE: rtl/core/trc_front.sv
// front end: classifies each incoming text byte
module trc_front (
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output trc_pkg::t_item o_item
);

    logic is_digit;
    logic is_upper;
    logic is_lower;
    logic [7:0] low_chr;

    always_comb begin
        is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        is_upper = (i_byte >= 8'h41) && (i_byte <= 8'h5a);
        is_lower = (i_byte >= 8'h61) && (i_byte <= 8'h7a);
        low_chr  = is_upper ? (i_byte | 8'h20) : i_byte;

        o_item.alnum      = is_digit || is_upper || is_lower;
        o_item.vowel      = trc_pkg::vowel_letter(low_chr);
        o_item.ender      = (i_byte == trc_pkg::CH_DOT) || (i_byte == trc_pkg::CH_BANG) ||
                            (i_byte == trc_pkg::CH_QUEST);
        o_item.final_byte = i_last;
        o_item.chr        = low_chr;
    end

endmodule

FILE: rtl/core/trc_queue.sv
// short fifo between the classifier and the counting back end
module trc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  trc_pkg::t_item i_wr_item,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output trc_pkg::t_item o_rd_item
);

    trc_pkg::t_item r_mem [trc_pkg::QUEUE_DEPTH];
    logic [trc_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [trc_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [trc_pkg::QCNT_BITS-1:0] r_count;
    logic push;
    logic pop;

    assign o_wr_ready = (r_count != trc_pkg::QCNT_BITS'(trc_pkg::QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/trc_back.sv
// back end: word and syllable tracking, saturating tallies and result register
module trc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  trc_pkg::t_item i_item,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output logic [127:0]   o_res_data
);

    localparam int CW = trc_pkg::COUNT_BITS;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [7:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + (CW+1)'(b);
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    function automatic logic [31:0] clamp32(input logic [CW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : w[31:0];
    endfunction

    logic          r_in_word, n_in_word;
    logic          r_in_vowel, n_in_vowel;
    logic [1:0]    r_len, n_len;
    logic [7:0]    r_last, n_last;
    logic [7:0]    r_second, n_second;
    logic [7:0]    r_syl, n_syl;
    logic [CW-1:0] r_words, n_words;
    logic [CW-1:0] r_sents, n_sents;
    logic [CW-1:0] r_syls, n_syls;
    logic [CW-1:0] r_chars, n_chars;
    logic          r_out_valid, n_out_valid;
    logic [127:0]  r_out_data, n_out_data;

    logic          take;
    logic          start;
    logic          b_vowel;
    logic [1:0]    b_len;
    logic [7:0]    b_last;
    logic [7:0]    b_syl;
    logic          w_inside;
    logic          w_vowel;
    logic [1:0]    w_len;
    logic [7:0]    w_last;
    logic [7:0]    w_second;
    logic [7:0]    w_syl;
    logic          finish;
    logic          silent_e;
    logic [7:0]    word_n;
    logic [CW-1:0] upd_words;
    logic [CW-1:0] upd_sents;
    logic [CW-1:0] upd_syls;
    logic [CW-1:0] upd_chars;
    logic [CW-1:0] sents_min1;

    // non-final items never wait on the result register
    assign o_ready     = !i_item.final_byte || !r_out_valid || i_res_ready;
    assign take        = i_valid && o_ready;
    assign o_res_valid = r_out_valid;
    assign o_res_data  = r_out_data;

    always_comb begin
        start   = i_item.alnum && !r_in_word;
        b_vowel = start ? 1'b0 : r_in_vowel;
        b_len   = start ? 2'd0 : r_len;
        b_last  = start ? 8'd0 : r_last;
        b_syl   = start ? 8'd0 : r_syl;

        if (i_item.alnum) begin
            w_inside = 1'b1;
            w_vowel  = i_item.vowel;
            w_len    = (b_len == 2'd3) ? 2'd3 : b_len + 2'd1;
            w_last   = i_item.chr;
            w_second = b_last;
            w_syl    = (i_item.vowel && !b_vowel && (b_syl != 8'hff)) ? b_syl + 8'd1 : b_syl;
        end else begin
            w_inside = r_in_word;
            w_vowel  = r_in_vowel;
            w_len    = r_len;
            w_last   = r_last;
            w_second = r_second;
            w_syl    = r_syl;
        end

        // word ends on a separator, or on the final byte of the text
        finish   = w_inside && (!i_item.alnum || i_item.final_byte);
        silent_e = (w_len == 2'd3) && (w_last == trc_pkg::CH_E) &&
                   !trc_pkg::vowel_letter(w_second) && (w_second != trc_pkg::CH_L) &&
                   (w_syl != 8'd0);
        word_n   = silent_e ? w_syl - 8'd1 : w_syl;
        if (word_n == 8'd0) begin
            word_n = 8'd1;
        end

        upd_words  = start ? sat_add(r_words, 8'd1) : r_words;
        upd_sents  = (!i_item.alnum && i_item.ender) ? sat_add(r_sents, 8'd1) : r_sents;
        upd_syls   = finish ? sat_add(r_syls, word_n) : r_syls;
        upd_chars  = sat_add(r_chars, 8'd1);
        sents_min1 = (upd_sents == '0) ? CW'(1) : upd_sents;

        n_in_word   = r_in_word;
        n_in_vowel  = r_in_vowel;
        n_len       = r_len;
        n_last      = r_last;
        n_second    = r_second;
        n_syl       = r_syl;
        n_words     = r_words;
        n_sents     = r_sents;
        n_syls      = r_syls;
        n_chars     = r_chars;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out_data  = r_out_data;

        if (take) begin
            if (i_item.final_byte) begin
                n_in_word   = 1'b0;
                n_in_vowel  = 1'b0;
                n_len       = 2'd0;
                n_last      = 8'd0;
                n_second    = 8'd0;
                n_syl       = 8'd0;
                n_words     = '0;
                n_sents     = '0;
                n_syls      = '0;
                n_chars     = '0;
                n_out_valid = 1'b1;
                n_out_data  = {clamp32(upd_chars), clamp32(upd_syls),
                               clamp32(sents_min1), clamp32(upd_words)};
            end else begin
                n_in_word   = finish ? 1'b0 : w_inside;
                n_in_vowel  = finish ? 1'b0 : w_vowel;
                n_len       = w_len;
                n_last      = w_last;
                n_second    = w_second;
                n_syl       = w_syl;
                n_words     = upd_words;
                n_sents     = upd_sents;
                n_syls      = upd_syls;
                n_chars     = upd_chars;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word   <= 1'b0;
            r_in_vowel  <= 1'b0;
            r_len       <= 2'd0;
            r_last      <= 8'd0;
            r_second    <= 8'd0;
            r_syl       <= 8'd0;
            r_words     <= '0;
            r_sents     <= '0;
            r_syls      <= '0;
            r_chars     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_word   <= n_in_word;
            r_in_vowel  <= n_in_vowel;
            r_len       <= n_len;
            r_last      <= n_last;
            r_second    <= n_second;
            r_syl       <= n_syl;
            r_words     <= n_words;
            r_sents     <= n_sents;
            r_syls      <= n_syls;
            r_chars     <= n_chars;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/core/text_readability_counter.sv
// Text readability counter: takes one text byte per item on the slave stream, with tlast on
// the final byte, and counts words (alphanumeric runs), syllables (vowel runs per word, with
// a silent final e rule and at least one per word), sentence enders and characters. On the
// final byte one result item carries the four saturating totals, and the counters clear.
// A byte is accepted every cycle while the queue has room: the classifier feeds a two-entry
// queue and the back end updates word state and all tallies as it takes each item, so
// throughput is one item per clock while nothing stalls. Results sit in an output register,
// so bytes of the next text keep flowing while a result waits; only a final byte stalls behind
// an untaken result. A final byte passes through the queue and then the result register.
module text_readability_counter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] text_byte
    input  logic         i_s_axis_tlast,   // end_of_text
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata    // words_total, sentences_total,
                                           // syllables_total, chars_total
);

    trc_pkg::t_item front_item;
    trc_pkg::t_item head_item;
    logic           head_valid;
    logic           head_ready;

    trc_front u_front (
        .i_byte (i_s_axis_tdata),
        .i_last (i_s_axis_tlast),
        .o_item (front_item)
    );

    trc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_s_axis_tvalid),
        .o_wr_ready (o_s_axis_tready),
        .i_wr_item  (front_item),
        .o_rd_valid (head_valid),
        .i_rd_ready (head_ready),
        .o_rd_item  (head_item)
    );

    trc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (head_valid),
        .o_ready     (head_ready),
        .i_item      (head_item),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res_data  (o_m_axis_tdata)
    );

endmodule

FILE: test/tb.sv
// testbench for text_readability_counter: directed and random texts against a predictor
`timescale 1ns / 1ps

module tb;

    localparam int CB         = trc_pkg::COUNT_BITS;
    localparam int IDLE_LIMIT = 3000;
    localparam int ITEM_GOAL  = 1350;

    // packed so that the layout matches the result tdata, words in the lowest bits
    typedef struct packed {
        logic [31:0] chars;
        logic [31:0] syllables;
        logic [31:0] sentences;
        logic [31:0] words;
    } t_totals;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         src_valid;
    logic         o_s_axis_tready;
    logic [7:0]   src_byte;
    logic         src_last;
    logic         o_m_axis_tvalid;
    logic         snk_ready = 1'b0;
    logic [127:0] o_m_axis_tdata;

    text_readability_counter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (src_byte),
        .i_s_axis_tlast  (src_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (snk_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // predictor state
    bit              in_word;
    bit              in_vowel_run;
    logic [1:0]      word_len;
    logic [7:0]      last_ch;
    logic [7:0]      prev_ch;
    logic [7:0]      word_syl;
    logic [CB-1:0]   words_cnt;
    logic [CB-1:0]   sentences_cnt;
    logic [CB-1:0]   syllables_cnt;
    logic [CB-1:0]   chars_cnt;

    t_totals pending_totals[$];

    int  n_errors = 0;
    int  bytes_sent;
    int  texts_sent;
    int  results_seen = 0;
    int  idle_cycles = 0;
    bit  src_gaps_on;
    bit  sink_idle_on;
    int  sink_hold_req;
    int  sink_wait = 0;

    always #5 i_clk = ~i_clk;

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB-1:0] top;
        top = '1;
        if (b > top - a)
            return top;
        return a + b;
    endfunction

    function automatic logic [31:0] clamp32(input logic [CB-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic bit vowel_ch(input logic [7:0] c);
        return c == trc_pkg::CH_A || c == trc_pkg::CH_E || c == trc_pkg::CH_I ||
               c == trc_pkg::CH_O || c == trc_pkg::CH_U || c == trc_pkg::CH_Y;
    endfunction

    function automatic bit alnum_ch(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void clear_text();
        in_word       = 0;
        in_vowel_run  = 0;
        word_len      = '0;
        last_ch       = '0;
        prev_ch       = '0;
        word_syl      = '0;
        words_cnt     = '0;
        sentences_cnt = '0;
        syllables_cnt = '0;
        chars_cnt     = '0;
    endfunction

    function automatic void close_word();
        logic [CB-1:0] n;
        n = CB'(word_syl);
        // silent final e after a consonant other than l
        if (word_len == 2'd3 && last_ch == trc_pkg::CH_E && !vowel_ch(prev_ch) &&
            prev_ch != trc_pkg::CH_L && n > 0)
            n = n - CB'(1);
        if (n == 0)
            n = CB'(1);
        syllables_cnt = sat_add(syllables_cnt, n);
        in_word      = 0;
        in_vowel_run = 0;
    endfunction

    // advance the predictor by one text byte; true when the byte closes the text
    function automatic bit count_text_byte(input logic [7:0] b, input bit last,
                                           output t_totals res);
        logic [7:0] c;
        bit         v;
        res = '0;
        chars_cnt = sat_add(chars_cnt, CB'(1));
        if (alnum_ch(b)) begin
            c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            v = vowel_ch(c);
            if (!in_word) begin
                in_word      = 1;
                in_vowel_run = 0;
                word_len     = '0;
                word_syl     = '0;
                last_ch      = '0;
                prev_ch      = '0;
                words_cnt    = sat_add(words_cnt, CB'(1));
            end
            if (v && !in_vowel_run && word_syl < 8'd255)
                word_syl = word_syl + 8'd1;
            in_vowel_run = v;
            if (word_len < 2'd3)
                word_len = word_len + 2'd1;
            prev_ch = last_ch;
            last_ch = c;
        end else begin
            if (in_word)
                close_word();
            if (b == trc_pkg::CH_DOT || b == trc_pkg::CH_BANG || b == trc_pkg::CH_QUEST)
                sentences_cnt = sat_add(sentences_cnt, CB'(1));
        end
        if (!last)
            return 0;
        if (in_word)
            close_word();
        res.words     = clamp32(words_cnt);
        res.sentences = clamp32(sentences_cnt == 0 ? CB'(1) : sentences_cnt);
        res.syllables = clamp32(syllables_cnt);
        res.chars     = clamp32(chars_cnt);
        clear_text();
        return 1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!src_gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last);
        int      gap;
        t_totals res;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            src_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        src_valid <= 1'b1;
        src_byte  <= b;
        src_last  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
        if (count_text_byte(b, last, res)) begin
            pending_totals.push_back(res);
            texts_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // sender stops until every result is in, then lets the pipeline settle
    task automatic wait_drain();
        @(negedge i_clk);
        src_valid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_word_rules();
        // silent e, le ending, digit before e, short word, uppercase
        send_text("The cake, 9e table.");
        send_text("Be");
        wait_drain();
    endtask

    task automatic test_odd_bytes();
        send_byte(8'h00, 1'b0);
        send_byte("A", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(trc_pkg::CH_QUEST, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte("x", 1'b1);
        // one-byte texts: a lone ender, and a lone word with no ender
        send_byte(trc_pkg::CH_BANG, 1'b1);
        send_byte("Q", 1'b1);
        wait_drain();
    endtask

    task automatic test_long_word();
        // the word syllable count saturates, then the silent e still takes one off
        for (int i = 0; i < 260; i++) begin
            send_byte("a", 1'b0);
            send_byte("b", 1'b0);
        end
        send_byte("e", 1'b0);
        send_byte(trc_pkg::CH_DOT, 1'b1);
        wait_drain();
    endtask

    task automatic test_backpressure();
        src_gaps_on   = 0;
        sink_hold_req = 300;
        // results back up, the block then holds off its input on a final byte
        repeat (30) send_byte(8'($urandom_range(97, 122)), 1'b1);
        wait_drain();
        src_gaps_on = 1;
    endtask

    task automatic send_random_text();
        string      letters;
        string      seps;
        int         len;
        int         r;
        logic [7:0] b;
        letters = "aeiouyeblltkrsnmdhcAEYSLT0729";
        seps    = " .,!?;-";
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 16);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                b = letters[$urandom_range(0, letters.len() - 1)];
            else if (r < 72)
                b = 8'($urandom_range(65, 90));
            else if (r < 92)
                b = seps[$urandom_range(0, seps.len() - 1)];
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic test_random_texts();
        while (bytes_sent < ITEM_GOAL) begin
            // stretches with and without idling on either side
            if ($urandom_range(0, 7) == 0) begin
                src_gaps_on  = $urandom_range(0, 3) != 0;
                sink_idle_on = $urandom_range(0, 3) != 0;
            end
            send_random_text();
        end
        wait_drain();
    endtask

    // result side ready, with random stalls and requested long holds
    always @(negedge i_clk) begin
        if (sink_hold_req > 0) begin
            sink_wait     = sink_hold_req;
            sink_hold_req = 0;
        end
        if (sink_wait > 0) begin
            sink_wait--;
            snk_ready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 99) < 20) begin
            sink_wait = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            snk_ready <= 1'b0;
        end else begin
            snk_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_totals got;
        t_totals want;
        if (i_rst_n && o_m_axis_tvalid && snk_ready) begin
            got = o_m_axis_tdata;
            results_seen++;
            if (pending_totals.size() == 0) begin
                $error("result item with no text pending: %h", o_m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_totals.pop_front();
                if (got.words !== want.words) begin
                    $error("words_total: expected %0d, got %0d", want.words, got.words);
                    n_errors++;
                end
                if (got.sentences !== want.sentences) begin
                    $error("sentences_total: expected %0d, got %0d",
                           want.sentences, got.sentences);
                    n_errors++;
                end
                if (got.syllables !== want.syllables) begin
                    $error("syllables_total: expected %0d, got %0d",
                           want.syllables, got.syllables);
                    n_errors++;
                end
                if (got.chars !== want.chars) begin
                    $error("chars_total: expected %0d, got %0d", want.chars, got.chars);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((src_valid && o_s_axis_tready) || (o_m_axis_tvalid && snk_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", IDLE_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        src_valid     = 1'b0;
        src_byte      = '0;
        src_last      = 1'b0;
        bytes_sent    = 0;
        texts_sent    = 0;
        src_gaps_on   = 1;
        sink_idle_on  = 1;
        sink_hold_req = 0;
        clear_text();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_word_rules();
        test_odd_bytes();
        test_long_word();
        test_backpressure();
        test_random_texts();

        repeat (10) @(posedge i_clk);
        $display("sent %0d text bytes in %0d texts, checked %0d result items",
                 bytes_sent, texts_sent, results_seen);
        $display("covered word rules, odd bytes, a saturating word, output backpressure");
        if (n_errors == 0 && pending_totals.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: text_readability_counter.f
rtl/core/trc_pkg.sv
rtl/core/trc_front.sv
rtl/core/trc_queue.sv
rtl/core/trc_back.sv
rtl/core/text_readability_counter.sv
test/tb.sv
